/* hdl/pehc_pkg.sv */
`timescale 1ns / 1ps

package pehc_pkg;

  // Length counter and offset widths
  localparam int LEN_W = 32;
  localparam int OFF_W = 32;
  localparam int CMP_W = ((LEN_W > OFF_W) ? LEN_W : OFF_W) + 2;
  localparam logic [LEN_W-1:0] LEN_SAT = '1;

  // Header store and window geometry
  localparam int HDR_DEPTH = 64;
  localparam int HDR_AW = 6;
  localparam int WIN_LEN = 96;
  localparam logic [HDR_AW-1:0] OFF_POS = 6'h3C;

  // Window bytes that the checks and fields need, one slot each
  localparam int NSLOT = 32;
  localparam int SLOT_W = 5;
  localparam int K_W = 7;

  localparam int SL_SIG = 0;
  localparam int SL_MACHINE = 4;
  localparam int SL_SECTIONS = 6;
  localparam int SL_STAMP = 8;
  localparam int SL_OPT = 12;
  localparam int SL_MAGIC = 14;
  localparam int SL_ENTRY = 16;
  localparam int SL_BASE64 = 20;
  localparam int SL_BASE32 = 24;
  localparam int SL_SUB32 = 28;
  localparam int SL_SUB64 = 30;

  // Header marks and limits
  localparam logic [7:0] MZ_M = 8'h4D;
  localparam logic [7:0] MZ_Z = 8'h5A;
  localparam logic [7:0] SIG_P = 8'h50;
  localparam logic [7:0] SIG_E = 8'h45;
  localparam logic [15:0] MAGIC_PE64 = 16'h020B;
  localparam logic [15:0] MAGIC_PE32 = 16'h010B;
  localparam int SIG_BYTES = 4;
  localparam int COFF_MIN = 20;
  localparam logic [15:0] OPT_MIN_MAGIC = 16'd2;
  localparam logic [15:0] OPT_MIN_PE64 = 16'd112;
  localparam logic [15:0] OPT_MIN_PE32 = 16'd96;

  // Status codes
  localparam logic [3:0] ST_OK = 4'd0;
  localparam logic [3:0] ST_SHORT = 4'd1;
  localparam logic [3:0] ST_NO_MZ = 4'd2;
  localparam logic [3:0] ST_OFF_RANGE = 4'd3;
  localparam logic [3:0] ST_NO_SIG = 4'd4;
  localparam logic [3:0] ST_COFF_RANGE = 4'd5;
  localparam logic [3:0] ST_OPT_RANGE = 4'd6;
  localparam logic [3:0] ST_PE64_SMALL = 4'd7;
  localparam logic [3:0] ST_PE32_SMALL = 4'd8;
  localparam logic [3:0] ST_BAD_MAGIC = 4'd9;

  typedef logic [NSLOT-1:0][7:0] slot_bytes_t;

  typedef struct packed {
    logic hit;
    logic [SLOT_W-1:0] idx;
  } slot_hit_t;

  // Per-file context handed from capture to evaluation
  typedef struct packed {
    logic pending;
    logic sweep_busy;
    logic mz_ok;
    logic [LEN_W-1:0] len;
    logic [OFF_W:0] off4;
    logic [OFF_W:0] off24;
  } ctx_t;

  typedef struct packed {
    logic [3:0] status;
    logic is_pe64;
    logic [15:0] machine_type;
    logic [15:0] section_count;
    logic [31:0] time_stamp;
    logic [31:0] entry_address;
    logic [63:0] base_address;
    logic [15:0] subsystem_code;
  } res_t;

  // Window position of a slot
  function automatic logic [K_W-1:0] slot_k(input logic [SLOT_W-1:0] idx);
    logic [K_W-1:0] k;
    k = {2'b00, idx};
    if (idx < 5'd12) k = {2'b00, idx};
    else if (idx < 5'd14) k = {2'b00, idx} + 7'd8;
    else if (idx < 5'd16) k = {2'b00, idx} + 7'd10;
    else if (idx < 5'd20) k = {2'b00, idx} + 7'd24;
    else if (idx < 5'd28) k = {2'b00, idx} + 7'd28;
    else if (idx < 5'd30) k = {2'b00, idx} + 7'd40;
    else k = {2'b00, idx} + 7'd62;
    return k;
  endfunction

  // Slot of a window position, if that byte is needed
  function automatic slot_hit_t k_slot(input logic [K_W-1:0] k);
    slot_hit_t r;
    r.hit = 1'b1;
    r.idx = '0;
    if (k < 7'd12) r.idx = k[SLOT_W-1:0];
    else if (k == 7'd20 || k == 7'd21) r.idx = SLOT_W'(k - 7'd8);
    else if (k == 7'd24 || k == 7'd25) r.idx = SLOT_W'(k - 7'd10);
    else if (k >= 7'd40 && k <= 7'd43) r.idx = SLOT_W'(k - 7'd24);
    else if (k >= 7'd48 && k <= 7'd55) r.idx = SLOT_W'(k - 7'd28);
    else if (k == 7'd68 || k == 7'd69) r.idx = SLOT_W'(k - 7'd40);
    else if (k == 7'd92 || k == 7'd93) r.idx = SLOT_W'(k - 7'd62);
    else r.hit = 1'b0;
    return r;
  endfunction

endpackage

/* hdl/pehc_ram.sv */
`timescale 1ns / 1ps

module pehc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/pehc_capture.sv */
`timescale 1ns / 1ps

module pehc_capture (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_fire,
  input  logic [7:0]            data_byte,
  input  logic                  last_byte,
  input  logic                  ev_fire,
  output pehc_pkg::ctx_t        ctx,
  output pehc_pkg::slot_bytes_t slots
);

  import pehc_pkg::*;

  logic [LEN_W-1:0]  pos;
  logic [LEN_W-1:0]  len_now;
  logic [OFF_W-1:0]  offset;
  logic [OFF_W-1:0]  offset_merge;
  logic              mz0;
  logic              mz1;
  logic              at_sat;
  logic              in_hdr;
  logic              take;
  logic              off_lane;
  logic [CMP_W-1:0]  diff;
  logic              in_win;
  slot_hit_t         st_hit;
  logic              st_we;
  logic              sw_act;
  logic [HDR_AW-1:0] sw_base;
  logic [SLOT_W-1:0] sw_idx;
  logic [K_W:0]      sw_sum;
  logic              rd_en;
  logic              rd_pend;
  logic [SLOT_W-1:0] rd_slot;
  logic [7:0]        ram_rdata;
  logic              sweep_start;

  // Position decode for the current request
  assign at_sat = (pos == LEN_SAT);
  assign in_hdr = (pos[LEN_W-1:HDR_AW] == '0);
  assign take = in_fire && !at_sat;
  assign off_lane = in_hdr && (pos[HDR_AW-1:0] >= OFF_POS);
  assign len_now = at_sat ? pos : pos + LEN_W'(1);
  assign sweep_start = take && in_hdr && (pos[HDR_AW-1:0] == HDR_AW'(HDR_DEPTH - 1));

  // Merge an offset byte as it passes
  always_comb begin
    offset_merge = offset;
    if (take && off_lane) begin
      offset_merge[{pos[1:0], 3'b000} +: 8] = data_byte;
    end
  end

  // Advance position and offset; restart on the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      offset <= '0;
    end else if (in_fire) begin
      if (last_byte) begin
        pos <= '0;
        offset <= '0;
      end else begin
        pos <= len_now;
        offset <= offset_merge;
      end
    end
  end

  // Hold the MZ mark
  always_ff @(posedge clk) begin
    if (take && in_hdr && pos[HDR_AW-1:0] == HDR_AW'(0)) begin
      mz0 <= (data_byte == MZ_M);
    end
    if (take && in_hdr && pos[HDR_AW-1:0] == HDR_AW'(1)) begin
      mz1 <= (data_byte == MZ_Z);
    end
  end

  // Window bytes beyond the header come straight off the stream
  assign diff = CMP_W'(pos) - CMP_W'(offset);
  assign in_win = !diff[CMP_W-1] && (diff < CMP_W'(WIN_LEN));
  assign st_hit = k_slot(diff[K_W-1:0]);
  assign st_we = take && !in_hdr && in_win && st_hit.hit;

  // Window bytes below 64 are read back from the header store
  assign sw_sum = {2'b00, sw_base} + {1'b0, slot_k(sw_idx)};
  assign rd_en = sw_act && (sw_sum[K_W:HDR_AW] == '0);

  pehc_ram #(
    .WIDTH(8),
    .DEPTH(HDR_DEPTH)
  ) u_hdr_ram (
    .clk   (clk),
    .we    (take && in_hdr),
    .waddr (pos[HDR_AW-1:0]),
    .wdata (data_byte),
    .re    (rd_en),
    .raddr (sw_sum[HDR_AW-1:0]),
    .rdata (ram_rdata)
  );

  // Step the read-back sweep over the slot list
  always_ff @(posedge clk) begin
    if (rst) begin
      sw_act <= 1'b0;
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= rd_en;
      if (sweep_start && offset_merge[OFF_W-1:HDR_AW] == '0) begin
        sw_act <= 1'b1;
      end else if (sw_act && sw_idx == SLOT_W'(NSLOT - 1)) begin
        sw_act <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_slot <= sw_idx;
    if (sweep_start) begin
      sw_base <= offset_merge[HDR_AW-1:0];
      sw_idx <= '0;
    end else if (sw_act) begin
      sw_idx <= sw_idx + SLOT_W'(1);
    end
  end

  // Fill slots from both sources; they never target the same slot
  always_ff @(posedge clk) begin
    if (st_we) begin
      slots[st_hit.idx] <= data_byte;
    end
    if (rd_pend) begin
      slots[rd_slot] <= ram_rdata;
    end
  end

  // Snapshot the file context on the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      ctx.pending <= 1'b0;
    end else if (in_fire && last_byte) begin
      ctx.pending <= 1'b1;
    end else if (ev_fire) begin
      ctx.pending <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && last_byte) begin
      ctx.len <= len_now;
      ctx.mz_ok <= mz0 && mz1;
      ctx.off4 <= {1'b0, offset_merge} + (OFF_W + 1)'(SIG_BYTES);
      ctx.off24 <= {1'b0, offset_merge} + (OFF_W + 1)'(SIG_BYTES + COFF_MIN);
    end
  end

  assign ctx.sweep_busy = sw_act || rd_pend;

  a_no_slot_clash: assert property (@(posedge clk) disable iff (rst)
    !(st_we && rd_pend && st_hit.idx == rd_slot))
    else $error("stream and read-back write the same slot");

  a_sweep_at_hdr_end: assert property (@(posedge clk) disable iff (rst)
    $rose(sw_act) |-> ($past(pos) == LEN_W'(HDR_DEPTH - 1)))
    else $error("read-back sweep started away from the header end");

endmodule

/* hdl/pehc_eval.sv */
`timescale 1ns / 1ps

module pehc_eval (
  input  logic                  clk,
  input  logic                  rst,
  input  pehc_pkg::ctx_t        ctx,
  input  pehc_pkg::slot_bytes_t slots,
  input  logic                  out_stall,
  output logic                  ev_fire,
  output logic                  out_valid,
  output pehc_pkg::res_t        res
);

  import pehc_pkg::*;

  logic [CMP_W-1:0] len_e;
  logic [CMP_W-1:0] off4_e;
  logic [CMP_W-1:0] off24_e;
  logic [CMP_W-1:0] opt_end;
  logic [15:0]      opt_size;
  logic [15:0]      magic;
  logic             sig_ok;
  res_t             res_new;
  res_t             out_res;
  res_t             skid_res;
  logic             out_full;
  logic             skid_full;
  logic             take;

  assign ev_fire = ctx.pending && !ctx.sweep_busy && !skid_full;

  // Range terms
  assign len_e = CMP_W'(ctx.len);
  assign off4_e = CMP_W'(ctx.off4);
  assign off24_e = CMP_W'(ctx.off24);
  assign opt_size = {slots[SL_OPT + 1], slots[SL_OPT]};
  assign magic = {slots[SL_MAGIC + 1], slots[SL_MAGIC]};
  assign opt_end = off24_e + CMP_W'(opt_size);
  assign sig_ok = (slots[SL_SIG] == SIG_P) && (slots[SL_SIG + 1] == SIG_E) &&
                  (slots[SL_SIG + 2] == 8'h00) && (slots[SL_SIG + 3] == 8'h00);

  // Apply the checks in file order and pick the fields
  always_comb begin
    res_new = '0;
    if (ctx.len < LEN_W'(HDR_DEPTH)) begin
      res_new.status = ST_SHORT;
    end else if (!ctx.mz_ok) begin
      res_new.status = ST_NO_MZ;
    end else if (len_e < off4_e) begin
      res_new.status = ST_OFF_RANGE;
    end else if (!sig_ok) begin
      res_new.status = ST_NO_SIG;
    end else if (len_e < off24_e) begin
      res_new.status = ST_COFF_RANGE;
    end else if (opt_size < OPT_MIN_MAGIC || opt_end > len_e) begin
      res_new.status = ST_OPT_RANGE;
    end else if (magic == MAGIC_PE64) begin
      res_new.is_pe64 = 1'b1;
      if (opt_size < OPT_MIN_PE64) begin
        res_new.status = ST_PE64_SMALL;
      end else begin
        res_new.status = ST_OK;
        res_new.machine_type = {slots[SL_MACHINE + 1], slots[SL_MACHINE]};
        res_new.section_count = {slots[SL_SECTIONS + 1], slots[SL_SECTIONS]};
        res_new.time_stamp = {slots[SL_STAMP + 3], slots[SL_STAMP + 2],
                              slots[SL_STAMP + 1], slots[SL_STAMP]};
        res_new.entry_address = {slots[SL_ENTRY + 3], slots[SL_ENTRY + 2],
                                 slots[SL_ENTRY + 1], slots[SL_ENTRY]};
        res_new.base_address = {slots[SL_BASE64 + 7], slots[SL_BASE64 + 6],
                                slots[SL_BASE64 + 5], slots[SL_BASE64 + 4],
                                slots[SL_BASE64 + 3], slots[SL_BASE64 + 2],
                                slots[SL_BASE64 + 1], slots[SL_BASE64]};
        res_new.subsystem_code = {slots[SL_SUB64 + 1], slots[SL_SUB64]};
      end
    end else if (magic == MAGIC_PE32) begin
      if (opt_size < OPT_MIN_PE32) begin
        res_new.status = ST_PE32_SMALL;
      end else begin
        res_new.status = ST_OK;
        res_new.machine_type = {slots[SL_MACHINE + 1], slots[SL_MACHINE]};
        res_new.section_count = {slots[SL_SECTIONS + 1], slots[SL_SECTIONS]};
        res_new.time_stamp = {slots[SL_STAMP + 3], slots[SL_STAMP + 2],
                              slots[SL_STAMP + 1], slots[SL_STAMP]};
        res_new.entry_address = {slots[SL_ENTRY + 3], slots[SL_ENTRY + 2],
                                 slots[SL_ENTRY + 1], slots[SL_ENTRY]};
        res_new.base_address = {32'h0000_0000,
                                slots[SL_BASE32 + 3], slots[SL_BASE32 + 2],
                                slots[SL_BASE32 + 1], slots[SL_BASE32]};
        res_new.subsystem_code = {slots[SL_SUB32 + 1], slots[SL_SUB32]};
      end
    end else begin
      res_new.status = ST_BAD_MAGIC;
    end
  end

  // Output register with a skid entry behind it
  assign take = out_full && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
      skid_full <= 1'b0;
    end else if (take) begin
      if (skid_full) begin
        skid_full <= 1'b0;
      end else if (!ev_fire) begin
        out_full <= 1'b0;
      end
    end else if (ev_fire) begin
      if (out_full) begin
        skid_full <= 1'b1;
      end else begin
        out_full <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && skid_full) begin
      out_res <= skid_res;
    end else if (ev_fire && (take || !out_full)) begin
      out_res <= res_new;
    end
    if (ev_fire && out_full && !take) begin
      skid_res <= res_new;
    end
  end

  assign out_valid = out_full;
  assign res = out_res;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_full |-> out_full)
    else $error("skid entry holds a request while the output is empty");

  a_fire_lands: assert property (@(posedge clk) disable iff (rst)
    ev_fire |=> out_full)
    else $error("evaluated request lost");

  a_failed_fields_clear: assert property (@(posedge clk) disable iff (rst)
    (out_full && out_res.status != ST_OK) |->
      (out_res.base_address == '0 && out_res.entry_address == '0 &&
       out_res.machine_type == '0 &&
       (out_res.is_pe64 == (out_res.status == ST_PE64_SMALL))))
    else $error("fields set on a failed header");

endmodule

/* hdl/pe_header_check_and_extract.sv */
`timescale 1ns / 1ps

// Checks a PE/COFF image header on a byte stream and extracts its main fields.
// Bytes are taken one per cycle unless stalled; one result follows each byte
// marked last, via the context and output registers. The first 64 bytes go to
// a 64-entry header RAM. When the header offset is below 64, the header RAM is
// read back for those of the 32 window bytes the checks use that lie in it, one
// read a cycle, starting after byte 63; a file that ends before this read-back
// finishes holds the next file's first byte until it does. Results go into an
// output register with one skid entry behind it, so the stream keeps flowing
// while a result waits; a file end is held back only when both are full.

module pe_header_check_and_extract (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  status,
  output logic        is_pe64,
  output logic [15:0] machine_type,
  output logic [15:0] section_count,
  output logic [31:0] time_stamp,
  output logic [31:0] entry_address,
  output logic [63:0] base_address,
  output logic [15:0] subsystem_code
);

  import pehc_pkg::*;

  ctx_t        ctx;
  slot_bytes_t slots;
  res_t        res;
  logic        ev_fire;
  logic        in_fire;

  // Hold the stream while the previous file's result cannot be formed
  assign in_stall = ctx.pending && !ev_fire;
  assign in_fire = in_valid && !in_stall;

  pehc_capture u_capture (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .ev_fire   (ev_fire),
    .ctx       (ctx),
    .slots     (slots)
  );

  pehc_eval u_eval (
    .clk       (clk),
    .rst       (rst),
    .ctx       (ctx),
    .slots     (slots),
    .out_stall (out_stall),
    .ev_fire   (ev_fire),
    .out_valid (out_valid),
    .res       (res)
  );

  assign status = res.status;
  assign is_pe64 = res.is_pe64;
  assign machine_type = res.machine_type;
  assign section_count = res.section_count;
  assign time_stamp = res.time_stamp;
  assign entry_address = res.entry_address;
  assign base_address = res.base_address;
  assign subsystem_code = res.subsystem_code;

endmodule

/* verif/pe_header_check_and_extract_tb.sv */
`timescale 1ns / 1ps

module pe_header_check_and_extract_tb;
  import pehc_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RAND_FILES = 50;
  localparam int CALM_TAIL = 6;
  localparam int DIR_ROWS = 24;

  // How the body of a generated image is filled before the header is placed
  localparam logic [1:0] FILL_RAND = 2'd0;
  localparam logic [1:0] FILL_ZERO = 2'd1;
  localparam logic [1:0] FILL_ONES = 2'd2;

  typedef struct packed {
    logic [15:0] size;
    logic [31:0] off;
    logic        mz;
    logic        sig;
    logic [15:0] opt;
    logic [15:0] magic;
    logic [1:0]  fill;
    logic        shape;
    logic        typed;
    logic [3:0]  want;
  } image_spec_t;

  typedef struct packed {
    logic typed;
    res_t r;
  } typed_res_t;

  // size, offset, mz, sig, opt size, magic, fill, shape, typed, status
  localparam image_spec_t DIR_TAB [DIR_ROWS] = '{
    '{   1,            0, 1, 1,     0,          0, FILL_RAND, 0, 1, ST_SHORT},
    '{  63,           64, 1, 1,     0,          0, FILL_RAND, 0, 1, ST_SHORT},
    '{  64,           64, 0, 1,     0,          0, FILL_ZERO, 0, 1, ST_NO_MZ},
    '{  64, 32'hFFFFFFFF, 1, 1,     0,          0, FILL_ONES, 0, 1, ST_OFF_RANGE},
    '{  64,           64, 1, 1,     0,          0, FILL_RAND, 0, 1, ST_OFF_RANGE},
    '{  64,           61, 1, 1,     0,          0, FILL_RAND, 1, 1, ST_OFF_RANGE},
    '{  67,           64, 1, 1,     0,          0, FILL_RAND, 1, 1, ST_OFF_RANGE},
    '{  64,            0, 1, 1,     0,          0, FILL_RAND, 1, 1, ST_NO_SIG},
    '{  64,           60, 1, 1,     0,          0, FILL_RAND, 1, 1, ST_NO_SIG},
    '{  68,           64, 1, 0,     0,          0, FILL_RAND, 1, 1, ST_NO_SIG},
    '{  87,           64, 1, 1,     0,          0, FILL_RAND, 1, 1, ST_COFF_RANGE},
    '{  88,           64, 1, 1,     0,          0, FILL_RAND, 1, 1, ST_OPT_RANGE},
    '{  90,           64, 1, 1,     3,   16'h1234, FILL_RAND, 1, 1, ST_OPT_RANGE},
    '{ 100,           64, 1, 1, 65535, MAGIC_PE64, FILL_RAND, 1, 1, ST_OPT_RANGE},
    '{  90,           64, 1, 1,     2,   16'h1234, FILL_RAND, 1, 1, ST_BAD_MAGIC},
    '{ 188,           64, 1, 1,   100,   16'h020A, FILL_RAND, 1, 1, ST_BAD_MAGIC},
    '{ 199,           64, 1, 1,   111, MAGIC_PE64, FILL_RAND, 1, 1, ST_PE64_SMALL},
    '{ 183,           64, 1, 1,    95, MAGIC_PE32, FILL_RAND, 1, 1, ST_PE32_SMALL},
    '{ 184,           64, 1, 1,    96, MAGIC_PE32, FILL_RAND, 1, 0, ST_OK},
    '{ 200,           64, 1, 1,   112, MAGIC_PE64, FILL_RAND, 1, 0, ST_OK},
    '{ 122,            2, 1, 1,    96, MAGIC_PE32, FILL_ZERO, 1, 0, ST_OK},
    '{ 180,           44, 1, 1,   112, MAGIC_PE64, FILL_ONES, 1, 0, ST_OK},
    '{ 150,            2, 1, 1,   124, MAGIC_PE64, FILL_RAND, 1, 0, ST_OK},
    '{ 260,          136, 1, 1,   100, MAGIC_PE32, FILL_ONES, 1, 0, ST_OK}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  status;
  logic        is_pe64;
  logic [15:0] machine_type;
  logic [15:0] section_count;
  logic [31:0] time_stamp;
  logic [31:0] entry_address;
  logic [63:0] base_address;
  logic [15:0] subsystem_code;

  // Predictor state
  logic [63:0] img_pos = '0;
  logic [63:0] img_off = '0;
  logic [7:0]  dos_hdr [HDR_DEPTH];
  logic [7:0]  pe_win [WIN_LEN];

  logic [7:0]  image_bytes [$];
  typed_res_t  typed_q [$];
  res_t        verdict_q [$];
  res_t        got_res;
  res_t        want_res;

  int          files_sent = 0;
  int          results_seen = 0;
  int          mismatch_cnt = 0;
  int unsigned cyc_cnt = 0;
  int          stall_left = 0;
  logic        idle_in = 1'b0;
  logic        idle_out = 1'b0;

  pe_header_check_and_extract DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .data_byte      (data_byte),
    .last_byte      (last_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .is_pe64        (is_pe64),
    .machine_type   (machine_type),
    .section_count  (section_count),
    .time_stamp     (time_stamp),
    .entry_address  (entry_address),
    .base_address   (base_address),
    .subsystem_code (subsystem_code)
  );

  always #5 clk = ~clk;

  // Byte at window position k, taken from the DOS header when it overlaps
  function automatic logic [7:0] win_byte(input int unsigned k);
    logic [63:0] p;
    p = img_off + k;
    if (p < HDR_DEPTH) return dos_hdr[p[5:0]];
    return pe_win[k];
  endfunction

  function automatic logic [63:0] win_word(input int unsigned k, input int unsigned n);
    logic [63:0] v;
    int unsigned i;
    v = '0;
    for (i = 0; i < n; i++) v = v | (64'(win_byte(k + i)) << (8 * i));
    return v;
  endfunction

  // Run the header checks in file order on a file of the given length
  function automatic res_t judge_image(input logic [63:0] len);
    res_t r;
    logic [63:0] off;
    logic [63:0] opt_sz;
    logic [63:0] magic;
    r = '0;
    off = img_off;
    if (len < HDR_DEPTH) begin
      r.status = ST_SHORT;
    end else if (dos_hdr[0] != MZ_M || dos_hdr[1] != MZ_Z) begin
      r.status = ST_NO_MZ;
    end else if (off > len || len - off < SIG_BYTES) begin
      r.status = ST_OFF_RANGE;
    end else if (win_byte(0) != SIG_P || win_byte(1) != SIG_E ||
                 win_byte(2) != 8'h00 || win_byte(3) != 8'h00) begin
      r.status = ST_NO_SIG;
    end else if (len - (off + SIG_BYTES) < COFF_MIN) begin
      r.status = ST_COFF_RANGE;
    end else begin
      opt_sz = win_word(20, 2);
      magic = win_word(24, 2);
      if (opt_sz < OPT_MIN_MAGIC || opt_sz > len - (off + 24)) begin
        r.status = ST_OPT_RANGE;
      end else if (magic == MAGIC_PE64) begin
        r.is_pe64 = 1'b1;
        if (opt_sz < OPT_MIN_PE64) begin
          r.status = ST_PE64_SMALL;
        end else begin
          r.entry_address = win_word(40, 4);
          r.base_address = win_word(48, 8);
          r.subsystem_code = win_word(92, 2);
        end
      end else if (magic == MAGIC_PE32) begin
        if (opt_sz < OPT_MIN_PE32) begin
          r.status = ST_PE32_SMALL;
        end else begin
          r.entry_address = win_word(40, 4);
          r.base_address = win_word(52, 4);
          r.subsystem_code = win_word(68, 2);
        end
      end else begin
        r.status = ST_BAD_MAGIC;
      end
    end
    // COFF fields only come out with a clean header
    if (r.status == ST_OK) begin
      r.machine_type = win_word(4, 2);
      r.section_count = win_word(6, 2);
      r.time_stamp = win_word(8, 4);
    end
    return r;
  endfunction

  // Capture one accepted byte; on the last byte queue the verdict and rewind
  task automatic absorb_byte(input logic [7:0] b, input logic fin);
    typed_res_t t;
    res_t r;
    if (img_pos < 64'(LEN_SAT)) begin
      if (img_pos < HDR_DEPTH) begin
        dos_hdr[img_pos[5:0]] = b;
        if (img_pos >= 64'(OFF_POS))
          img_off = img_off | (64'(b) << (8 * (img_pos - 64'(OFF_POS))));
      end else if (img_pos >= img_off && img_pos - img_off < WIN_LEN) begin
        pe_win[7'(img_pos - img_off)] = b;
      end
      img_pos = img_pos + 1;
    end
    if (fin) begin
      r = judge_image(img_pos);
      t = typed_q.pop_front();
      verdict_q.push_back(t.typed ? t.r : r);
      img_pos = '0;
      img_off = '0;
    end
  endtask

  function automatic void put_le(input logic [63:0] at, input logic [63:0] val,
                                 input int unsigned n);
    int unsigned i;
    for (i = 0; i < n; i++) begin
      if (at + i < image_bytes.size()) image_bytes[at + i] = val[8*i +: 8];
    end
  endfunction

  // Lay out one file: body, then PE header pieces, then MZ mark and offset
  function automatic void build_image(input image_spec_t s);
    int i;
    image_bytes.delete();
    for (i = 0; i < s.size; i++) begin
      case (s.fill)
        FILL_ZERO: image_bytes.push_back(8'h00);
        FILL_ONES: image_bytes.push_back(8'hFF);
        default: image_bytes.push_back(8'($urandom_range(0, 255)));
      endcase
    end
    if (s.shape) begin
      put_le(s.off, s.sig ? {8'h00, 8'h00, SIG_E, SIG_P} : {8'h01, 8'h00, SIG_E, SIG_P}, 4);
      put_le(64'(s.off) + 20, s.opt, 2);
      put_le(64'(s.off) + 24, s.magic, 2);
    end
    put_le(0, s.mz ? {MZ_Z, MZ_M} : {~MZ_Z, MZ_M}, 2);
    put_le(64'(OFF_POS), s.off, 4);
  endfunction

  // Pick a mostly well-formed file with random content and the odd defect
  function automatic image_spec_t rand_spec();
    image_spec_t s;
    int unsigned pick;
    s = '0;
    pick = $urandom_range(0, 19);
    s.fill = (pick == 0) ? FILL_ZERO : (pick == 1) ? FILL_ONES : FILL_RAND;
    s.mz = ($urandom_range(0, 19) != 0);
    s.sig = ($urandom_range(0, 19) != 0);
    s.shape = 1'b1;
    pick = $urandom_range(0, 99);
    if (pick < 30) s.off = 32'($urandom_range(2, 63));
    else if (pick < 90) s.off = 32'($urandom_range(64, 160));
    else if (pick < 95) s.off = 32'($urandom_range(0, 1));
    else s.off = $urandom();
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      s.magic = MAGIC_PE32;
      s.opt = OPT_MIN_PE32 + 16'($urandom_range(0, 48));
    end else if (pick < 90) begin
      s.magic = MAGIC_PE64;
      s.opt = OPT_MIN_PE64 + 16'($urandom_range(0, 48));
    end else begin
      s.magic = 16'($urandom_range(0, 65535));
      s.opt = 16'($urandom_range(2, 120));
    end
    if ($urandom_range(0, 9) == 0)
      s.opt = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 111))
                                           : 16'($urandom_range(0, 65535));
    if (s.off > 400) begin
      s.size = 16'($urandom_range(64, 120));
    end else begin
      s.size = 16'(s.off + 24 + ((s.opt > 200) ? 200 : s.opt) + $urandom_range(0, 6));
      if ($urandom_range(0, 9) == 0) s.size = 16'($urandom_range(1, s.size));
    end
    // Plain noise now and then
    if ($urandom_range(0, 9) == 0) begin
      s.shape = 1'b0;
      s.size = 16'($urandom_range(1, 140));
    end
    return s;
  endfunction

  // Send the built file one request at a time, with random idle bursts
  task automatic send_image(input logic typed, input logic [3:0] want);
    typed_res_t t;
    int i;
    t = '0;
    t.typed = typed;
    t.r.status = want;
    t.r.is_pe64 = (want == ST_PE64_SMALL);
    typed_q.push_back(t);
    for (i = 0; i < image_bytes.size(); i++) begin
      if (idle_in && $urandom_range(0, 11) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      in_valid <= 1'b1;
      data_byte <= image_bytes[i];
      last_byte <= (i == image_bytes.size() - 1);
      @(posedge clk);
      while (in_stall) @(posedge clk);
    end
    files_sent++;
  endtask

  // Hold the sender until every queued verdict has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_seen != files_sent) @(posedge clk);
  endtask

  // Track accepted requests
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) absorb_byte(data_byte, last_byte);
  end

  // Check results and drive receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        got_res = {status, is_pe64, machine_type, section_count, time_stamp,
                   entry_address, base_address, subsystem_code};
        if (verdict_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected result: st=%0d pe64=%0d mach=%h", status, is_pe64,
                     machine_type);
        end else begin
          want_res = verdict_q.pop_front();
          if (got_res !== want_res) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
              $display("result %0d want: st=%0d pe64=%0d mach=%h sec=%h ts=%h ep=%h base=%h sub=%h",
                       results_seen, want_res.status, want_res.is_pe64,
                       want_res.machine_type, want_res.section_count, want_res.time_stamp,
                       want_res.entry_address, want_res.base_address,
                       want_res.subsystem_code);
              $display("result %0d got:  st=%0d pe64=%0d mach=%h sec=%h ts=%h ep=%h base=%h sub=%h",
                       results_seen, status, is_pe64, machine_type, section_count,
                       time_stamp, entry_address, base_address, subsystem_code);
            end
          end
        end
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else if (idle_out && $urandom_range(0, 11) == 0) begin
        stall_left <= $urandom_range(0, 14);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int r;
    int f;
    int k;
    image_spec_t s;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    idle_out <= 1'b1;
    idle_in = 1'b1;

    // Directed files: length edges, every status, field extremes
    for (r = 0; r < DIR_ROWS; r++) begin
      build_image(DIR_TAB[r]);
      send_image(DIR_TAB[r].typed, DIR_TAB[r].want);
    end
    wait_drained();

    // Random files; calm stretches, periodic drains, quiet tail
    for (f = 0; f < RAND_FILES; f++) begin
      if (f % 12 == 11) wait_drained();
      idle_in = (f < RAND_FILES - CALM_TAIL) && ($urandom_range(0, 4) != 0);
      idle_out <= (f < RAND_FILES - CALM_TAIL) && ($urandom_range(0, 4) != 0);
      s = rand_spec();
      build_image(s);
      if ($urandom_range(0, 9) == 0) begin
        k = $urandom_range(0, image_bytes.size() - 1);
        image_bytes[k] = image_bytes[k] ^ (8'h01 << $urandom_range(0, 7));
      end
      send_image(1'b0, ST_OK);
    end

    wait_drained();
    repeat (40) @(posedge clk);
    mismatch_cnt += verdict_q.size();
    if (mismatch_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/pehc_pkg.sv
hdl/pehc_ram.sv
hdl/pehc_capture.sv
hdl/pehc_eval.sv
hdl/pe_header_check_and_extract.sv
verif/pe_header_check_and_extract_tb.sv
